FILE: src/diff_drive_odometry_fusion_macros.svh
// assertion macros for the rtl, used by ddof_ctrl
`ifndef DIFF_DRIVE_ODOMETRY_FUSION_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_FUSION_MACROS_SVH

// property that holds outside reset
`define DDOF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the next clock
`define DDOF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ddof_pkg.sv
`default_nettype none
package ddof_pkg;

   localparam int DIST_PER_COUNT_DEF = 68400;
   localparam int INV_WHEEL_BASE_DEF = 5008000;
   localparam int GYRO_SCALE_DEF     = 2562;
   localparam int ACCEL_SCALE_DEF    = 1023;
   localparam int CORDIC_STEPS_DEF   = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [19:0] Q16_TWO_PI  = 20'sd411775;
   localparam logic signed [19:0] Q16_PI      = 20'sd205887;
   localparam logic signed [19:0] Q16_HALF_PI = 20'sd102944;
   localparam logic signed [31:0] ACC_SMALL   = 32'sd1966;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // register indexes
   localparam logic [2:0] REG_GYRO_OFFSET_Z    = 3'd0;
   localparam logic [2:0] REG_GYRO_NOISE_LEVEL = 3'd1;
   localparam logic [2:0] REG_ACCEL_OFFSET_X   = 3'd2;
   localparam logic [2:0] REG_ACCEL_OFFSET_Y   = 3'd3;
   localparam logic [2:0] REG_ACCEL_NOISE_X    = 3'd4;
   localparam logic [2:0] REG_ACCEL_NOISE_Y    = 3'd5;
   localparam logic [2:0] REG_GYRO_WEIGHT      = 3'd6;
   localparam logic [2:0] REG_FUSED_WEIGHT     = 3'd7;

   localparam logic [16:0] GYRO_WEIGHT_RST  = 17'd62259;
   localparam logic [16:0] FUSED_WEIGHT_RST = 17'd32768;

   // datapath phase commands
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_PREP    = 4'd2;
   localparam logic [3:0] OP_DGYRO   = 4'd3;
   localparam logic [3:0] OP_ATAN    = 4'd4;
   localparam logic [3:0] OP_BLEND1  = 4'd5;
   localparam logic [3:0] OP_BLEND2  = 4'd6;
   localparam logic [3:0] OP_HEAD    = 4'd7;
   localparam logic [3:0] OP_SINCOS  = 4'd8;
   localparam logic [3:0] OP_POS     = 4'd9;
   localparam logic [3:0] OP_BLEND1B = 4'd10;
   localparam logic [3:0] OP_BLEND2B = 4'd11;
   localparam logic [3:0] OP_POSB    = 4'd12;

   typedef struct packed {
      logic [3:0] op;
      logic       cordic_init;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic signed [15:0] gyro_offset_z;
      logic        [14:0] gyro_noise_level;
      logic signed [15:0] accel_offset_x;
      logic signed [15:0] accel_offset_y;
      logic        [14:0] accel_noise_x;
      logic        [14:0] accel_noise_y;
      logic        [16:0] gyro_weight;
      logic        [16:0] fused_weight;
   } cfg_type;

   function automatic logic signed [19:0] atan_lookup(input logic [4:0] i);
      logic signed [19:0] r;
      begin
         case (i)
            5'd0: r = 20'sd51472;
            5'd1: r = 20'sd30386;
            5'd2: r = 20'sd16055;
            5'd3: r = 20'sd8150;
            5'd4: r = 20'sd4091;
            5'd5: r = 20'sd2047;
            5'd6: r = 20'sd1024;
            5'd7: r = 20'sd512;
            5'd8: r = 20'sd256;
            5'd9: r = 20'sd128;
            5'd10: r = 20'sd64;
            5'd11: r = 20'sd32;
            5'd12: r = 20'sd16;
            5'd13: r = 20'sd8;
            5'd14: r = 20'sd4;
            5'd15: r = 20'sd2;
            5'd16: r = 20'sd1;
            default: r = 20'sd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

FILE: src/ddof_ctrl.sv
`default_nettype none
module ddof_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  ddof_pkg::status_type status,
   output ddof_pkg::cmd_type    cmd
);
   import ddof_pkg::*;
   `include "diff_drive_odometry_fusion_macros.svh"

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PREP    = 4'd1;
   localparam logic [3:0] S_DIV     = 4'd2;
   localparam logic [3:0] S_ATAN    = 4'd3;
   localparam logic [3:0] S_BLEND1  = 4'd4;
   localparam logic [3:0] S_BLEND1B = 4'd5;
   localparam logic [3:0] S_BLEND2  = 4'd6;
   localparam logic [3:0] S_BLEND2B = 4'd7;
   localparam logic [3:0] S_HEAD    = 4'd8;
   localparam logic [3:0] S_SINCOS  = 4'd9;
   localparam logic [3:0] S_POS     = 4'd10;
   localparam logic [3:0] S_POSB    = 4'd11;
   localparam logic [3:0] S_OUT     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op = OP_PREP;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DGYRO;
            if (status.div_done) begin
               cmd.cordic_init = 1'b1;
               state_in = S_ATAN;
            end
         end
         S_ATAN: begin
            cmd.op = OP_ATAN;
            if (status.cordic_done) state_in = S_BLEND1;
         end
         S_BLEND1: begin
            cmd.op = OP_BLEND1;
            state_in = S_BLEND1B;
         end
         S_BLEND1B: begin
            cmd.op = OP_BLEND1B;
            state_in = S_BLEND2;
         end
         S_BLEND2: begin
            cmd.op = OP_BLEND2;
            state_in = S_BLEND2B;
         end
         S_BLEND2B: begin
            cmd.op = OP_BLEND2B;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.op = OP_HEAD;
            cmd.cordic_init = 1'b1;
            state_in = S_SINCOS;
         end
         S_SINCOS: begin
            cmd.op = OP_SINCOS;
            if (status.cordic_done) state_in = S_POS;
         end
         S_POS: begin
            cmd.op = OP_POS;
            state_in = S_POSB;
         end
         S_POSB: begin
            cmd.op = OP_POSB;
            state_in = S_OUT;
         end
         S_OUT: begin
            // wait until the previous beat has left the output register
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DDOF_ASSERT(a_publish_free, clock, reset, !(cmd.publish && rsp_valid_ff && !rsp_ready), "publish over a held beat")
   `DDOF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff == S_PREP, "accept did not start work")
   `DDOF_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff, "publish without valid")
endmodule
`default_nettype wire

FILE: src/ddof_datapath.sv
`default_nettype none
module ddof_datapath #(
   parameter int DIST_PER_COUNT = ddof_pkg::DIST_PER_COUNT_DEF,
   parameter int INV_WHEEL_BASE = ddof_pkg::INV_WHEEL_BASE_DEF,
   parameter int GYRO_SCALE     = ddof_pkg::GYRO_SCALE_DEF,
   parameter int ACCEL_SCALE    = ddof_pkg::ACCEL_SCALE_DEF,
   parameter int CORDIC_STEPS   = ddof_pkg::CORDIC_STEPS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ddof_pkg::cmd_type    cmd,
   output ddof_pkg::status_type status,
   input  ddof_pkg::cfg_type    cfg,
   input  wire signed [15:0]    req_left_counts,
   input  wire signed [15:0]    req_right_counts,
   input  wire signed [15:0]    req_gyro_z_raw,
   input  wire signed [15:0]    req_accel_x_raw,
   input  wire signed [15:0]    req_accel_y_raw,
   input  wire        [15:0]    req_elapsed_ms,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic       [18:0]    rsp_heading,
   output logic signed [31:0]   rsp_travel_distance
);
   import ddof_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   // input capture
   logic signed [15:0] lc_ff, rc_ff, g_ff, ax_raw_ff, ay_raw_ff;
   logic        [15:0] dt_ff;

   // state
   logic signed [31:0] gx_ff, gy_ff, ctot_ff, center_ff;
   logic signed [31:0] rate_now_ff, rate_before_ff;
   logic signed [19:0] heading_ff;

   // working values
   logic signed [31:0] ax_ff, ay_ff, d_enc_ff, d_gyro_ff, d_acc_ff, ang_ff;
   logic signed [63:0] prod_a_ff, prod_b_ff;

   // output register
   logic signed [31:0] out_x_ff, out_y_ff, out_t_ff;
   logic        [18:0] out_h_ff;

   // gyro increment divide by 2000: |num| < 2^37, shifted right by 4, then
   // multiplied by the reciprocal of 125 scaled by 2^40, in two halves
   localparam logic [33:0] DIV_RECIP = 34'd8796093023;
   logic [32:0]        div_mag_ff;
   logic [50:0]        div_plo_ff;
   logic [49:0]        div_phi_ff;
   logic [25:0]        div_q_ff;
   logic [1:0]         div_cnt_ff;
   logic               div_neg_ff, div_busy_ff;
   logic signed [50:0] div_num;
   logic        [50:0] div_abs;

   // cordic unit
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [21:0] cz_ff;
   logic [4:0]         ci_ff;
   logic               cmode_ff; // 1 = rotation for sin/cos
   logic               cneg_ff, cbusy_ff;
   logic               cordic_zero;

   // prep combinational
   logic signed [17:0] lr_sum, lr_dif;
   logic signed [63:0] center_prod, enc_prod;
   logic               gyro_pass;
   logic signed [17:0] g_adj, axa, aya;
   logic signed [31:0] g_scaled, ax_v, ay_v;
   logic               ax_pass, ay_pass;

   function automatic logic signed [31:0] accel_scale(input logic signed [17:0] v);
      logic signed [47:0] p;
      begin
         p = 48'(v) * 48'(ACCEL_SCALE);
         return 32'(p >>> 8);
      end
   endfunction

   always_comb begin
      lr_sum = 18'(lc_ff) + 18'(rc_ff);
      lr_dif = 18'(rc_ff) - 18'(lc_ff);
      center_prod = 64'(lr_sum) * 64'(DIST_PER_COUNT);
      enc_prod = 64'(lr_dif) * 64'(DIST_PER_COUNT);
      gyro_pass = (18'(g_ff) >= $signed({3'b0, cfg.gyro_noise_level}))
               || (18'(g_ff) <= -$signed({3'b0, cfg.gyro_noise_level}));
      g_adj = 18'(g_ff) - 18'(cfg.gyro_offset_z);
      g_scaled = 32'((48'(g_adj) * 48'(GYRO_SCALE)) >>> 8);
      ax_pass = (18'(ax_raw_ff) >= $signed({2'b0, cfg.accel_noise_x, 1'b0}))
             || (18'(ax_raw_ff) <= -$signed({2'b0, cfg.accel_noise_x, 1'b0}));
      ay_pass = (18'(ay_raw_ff) >= $signed({2'b0, cfg.accel_noise_y, 1'b0}))
             || (18'(ay_raw_ff) <= -$signed({2'b0, cfg.accel_noise_y, 1'b0}));
      axa = 18'(ax_raw_ff) - 18'(cfg.accel_offset_x);
      aya = 18'(ay_raw_ff) - 18'(cfg.accel_offset_y);
      ax_v = accel_scale(axa);
      ay_v = accel_scale(aya);
      if (!ax_pass || (ax_v <= ACC_SMALL && ax_v >= -ACC_SMALL)) ax_v = '0;
      if (!ay_pass || (ay_v <= ACC_SMALL && ay_v >= -ACC_SMALL)) ay_v = '0;
      div_num = 51'((51'(rate_before_ff) + 51'(rate_now_ff)) * $signed({35'b0, dt_ff}));
      div_abs = (div_num < 0) ? 51'(-div_num) : 51'(div_num);
   end

   assign cordic_zero = (cx_ff == '0) && (cy_ff == '0);
   assign status.cordic_done = !cbusy_ff;
   assign status.div_done = div_busy_ff && (div_cnt_ff == 2'd2);

   // heading update
   logic signed [32:0] th;
   logic signed [21:0] zr;
   logic               sc_neg;
   always_comb begin
      th = 33'(heading_ff) + 33'(ang_ff);
      if (th > 33'(Q16_TWO_PI)) th = th - 33'(Q16_TWO_PI);
      else if (th < 0) th = th + 33'(Q16_TWO_PI);
      if (th < 0) th = '0;
      if (th > 33'(Q16_TWO_PI)) th = 33'(Q16_TWO_PI);
      zr = 22'(th);
      sc_neg = 1'b0;
      if (zr > 22'(Q16_PI)) zr = zr - 22'(Q16_TWO_PI);
      if (zr > 22'(Q16_HALF_PI)) begin
         zr = zr - 22'(Q16_PI);
         sc_neg = 1'b1;
      end else if (zr < -22'(Q16_HALF_PI)) begin
         zr = zr + 22'(Q16_PI);
         sc_neg = 1'b1;
      end
   end

   logic signed [35:0] xs, ys;
   logic signed [21:0] at;
   logic               dir;
   always_comb begin
      xs = cx_ff >>> ci_ff;
      ys = cy_ff >>> ci_ff;
      at = 22'(atan_lookup(ci_ff));
      dir = cmode_ff ? (cz_ff >= 0) : (cy_ff <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= '0;
         gy_ff <= '0;
         ctot_ff <= '0;
         rate_now_ff <= '0;
         rate_before_ff <= '0;
         heading_ff <= '0;
         cbusy_ff <= 1'b0;
         div_busy_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               lc_ff <= req_left_counts;
               rc_ff <= req_right_counts;
               g_ff <= req_gyro_z_raw;
               ax_raw_ff <= req_accel_x_raw;
               ay_raw_ff <= req_accel_y_raw;
               dt_ff <= req_elapsed_ms;
            end
            OP_PREP: begin
               center_ff <= 32'(center_prod >>> 17);
               ctot_ff <= ctot_ff + 32'(center_prod >>> 17);
               if (gyro_pass) begin
                  rate_before_ff <= rate_now_ff;
                  rate_now_ff <= g_scaled;
               end else begin
                  rate_now_ff <= '0;
               end
               ax_ff <= ax_v;
               ay_ff <= ay_v;
               prod_a_ff <= enc_prod;
               div_busy_ff <= 1'b0;
            end
            OP_DGYRO: begin
               if (!div_busy_ff) begin
                  // second multiply of the encoder turn term
                  prod_b_ff <= (prod_a_ff * 64'(INV_WHEEL_BASE)) >>> 32;
                  div_busy_ff <= 1'b1;
                  div_cnt_ff <= 2'd0;
                  div_neg_ff <= div_num < 0;
                  div_mag_ff <= div_abs[36:4];
               end else if (div_cnt_ff == 2'd0) begin
                  div_cnt_ff <= 2'd1;
                  div_plo_ff <= 51'(div_mag_ff[16:0]) * 51'(DIV_RECIP);
                  div_phi_ff <= 50'(div_mag_ff[32:17]) * 50'(DIV_RECIP);
               end else if (div_cnt_ff == 2'd1) begin
                  div_cnt_ff <= 2'd2;
                  div_q_ff <= 26'((51'(div_phi_ff) + (div_plo_ff >> 17)) >> 23);
               end else begin
                  d_gyro_ff <= div_neg_ff ? -32'(div_q_ff) : 32'(div_q_ff);
                  d_enc_ff <= 32'(prod_b_ff);
                  // cordic vectoring setup with quadrant fold
                  cmode_ff <= 1'b0;
                  ci_ff <= '0;
                  cbusy_ff <= 1'b1;
                  if (ax_ff < 0) begin
                     if (ay_ff >= 0) begin
                        cx_ff <= 36'(ay_ff);
                        cy_ff <= -36'(ax_ff);
                        cz_ff <= 22'(Q16_HALF_PI);
                     end else begin
                        cx_ff <= -36'(ay_ff);
                        cy_ff <= 36'(ax_ff);
                        cz_ff <= -22'(Q16_HALF_PI);
                     end
                  end else begin
                     cx_ff <= 36'(ax_ff);
                     cy_ff <= 36'(ay_ff);
                     cz_ff <= '0;
                  end
               end
            end
            OP_ATAN, OP_SINCOS: begin
               if (cbusy_ff) begin
                  if (!cmode_ff && ci_ff == '0 && cordic_zero) begin
                     cz_ff <= '0;
                     cbusy_ff <= 1'b0;
                  end else begin
                     if (dir) begin
                        cx_ff <= cx_ff - ys;
                        cy_ff <= cy_ff + xs;
                        cz_ff <= cz_ff - at;
                     end else begin
                        cx_ff <= cx_ff + ys;
                        cy_ff <= cy_ff - xs;
                        cz_ff <= cz_ff + at;
                     end
                     ci_ff <= ci_ff + 5'd1;
                     if (ci_ff == 5'(STEPS - 1)) cbusy_ff <= 1'b0;
                  end
               end
               if (cmd.op == OP_ATAN && !cbusy_ff) d_acc_ff <= 32'(cz_ff);
            end
            OP_BLEND1: begin
               prod_a_ff <= 64'($signed({15'b0, cfg.gyro_weight})) * 64'(d_gyro_ff);
               prod_b_ff <= (64'sd65536 - 64'($signed({15'b0, cfg.gyro_weight})))
                            * 64'(d_acc_ff);
            end
            OP_BLEND1B: ang_ff <= 32'((prod_a_ff + prod_b_ff) >>> 16);
            OP_BLEND2: begin
               prod_a_ff <= 64'($signed({15'b0, cfg.fused_weight})) * 64'(ang_ff);
               prod_b_ff <= (64'sd65536 - 64'($signed({15'b0, cfg.fused_weight})))
                            * 64'(d_enc_ff);
            end
            OP_BLEND2B: ang_ff <= 32'((prod_a_ff + prod_b_ff) >>> 16);
            OP_HEAD: begin
               heading_ff <= 20'(th);
            end
            OP_POS: begin
               if (cneg_ff) begin
                  prod_a_ff <= -(64'(center_ff) * 64'(cx_ff));
                  prod_b_ff <= -(64'(center_ff) * 64'(cy_ff));
               end else begin
                  prod_a_ff <= 64'(center_ff) * 64'(cx_ff);
                  prod_b_ff <= 64'(center_ff) * 64'(cy_ff);
               end
            end
            OP_POSB: begin
               gx_ff <= gx_ff + 32'(prod_a_ff >>> 30);
               gy_ff <= gy_ff + 32'(prod_b_ff >>> 30);
            end
            default: ;
         endcase
         // sin/cos setup from the new heading as it is stored
         if (cmd.cordic_init && cmd.op == OP_HEAD) begin
            cmode_ff <= 1'b1;
            cbusy_ff <= 1'b1;
            ci_ff <= '0;
            cx_ff <= 36'(CORDIC_GAIN);
            cy_ff <= '0;
            cz_ff <= zr;
            cneg_ff <= sc_neg;
         end
         if (cmd.op == OP_SINCOS && cbusy_ff && cmode_ff && ci_ff == 5'(STEPS - 1)) begin
            cmode_ff <= 1'b0;
         end
      end
      if (cmd.publish) begin
         out_x_ff <= gx_ff;
         out_y_ff <= gy_ff;
         out_h_ff <= heading_ff[18:0];
         out_t_ff <= ctot_ff;
      end
   end

   assign rsp_pos_x = out_x_ff;
   assign rsp_pos_y = out_y_ff;
   assign rsp_heading = out_h_ff;
   assign rsp_travel_distance = out_t_ff;
endmodule
`default_nettype wire

FILE: src/diff_drive_odometry_fusion.sv
// differential-drive odometry with a two-stage complementary heading filter
// req channel: one beat per odometry tick (encoder deltas, gyro z, accel x/y,
//   elapsed ms); req_ready is high only while the block is idle
// rsp channel: one beat per tick with pos_x, pos_y, heading and travel
//   distance, held in an output register until rsp_ready takes it
// the gyro divide by 2000 is a reciprocal multiply, and the shared cordic
//   unit runs atan2 then sin/cos, 16 steps each (atan2 gives zero without
//   its steps when the accel vector is zero)
// a new beat is accepted only after the previous tick is finished, and may
//   be accepted while the previous result still waits in the output register
// a stalled rsp holds the block at its final step until the beat is taken
// csr port: write enable, index and 17-bit data; write only while idle
// reset: synchronous, clears position, heading, rates and distance totals,
//   loads the default blend weights and zero offsets and noise levels
`default_nettype none
module diff_drive_odometry_fusion #(
   parameter int DIST_PER_COUNT = ddof_pkg::DIST_PER_COUNT_DEF,
   parameter int INV_WHEEL_BASE = ddof_pkg::INV_WHEEL_BASE_DEF,
   parameter int GYRO_SCALE     = ddof_pkg::GYRO_SCALE_DEF,
   parameter int ACCEL_SCALE    = ddof_pkg::ACCEL_SCALE_DEF,
   parameter int CORDIC_STEPS   = ddof_pkg::CORDIC_STEPS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire signed [15:0] req_left_counts,
   input  wire signed [15:0] req_right_counts,
   input  wire signed [15:0] req_gyro_z_raw,
   input  wire signed [15:0] req_accel_x_raw,
   input  wire signed [15:0] req_accel_y_raw,
   input  wire        [15:0] req_elapsed_ms,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic       [18:0] rsp_heading,
   output logic signed [31:0] rsp_travel_distance,
   input  wire               csr_we,
   input  wire        [2:0]  csr_index,
   input  wire        [16:0] csr_data
);
   import ddof_pkg::*;

   cmd_type    cmd;
   status_type status;
   cfg_type    cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gyro_weight: GYRO_WEIGHT_RST, fused_weight: FUSED_WEIGHT_RST,
                     default: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GYRO_OFFSET_Z:    cfg_ff.gyro_offset_z <= csr_data[15:0];
            REG_GYRO_NOISE_LEVEL: cfg_ff.gyro_noise_level <= csr_data[14:0];
            REG_ACCEL_OFFSET_X:   cfg_ff.accel_offset_x <= csr_data[15:0];
            REG_ACCEL_OFFSET_Y:   cfg_ff.accel_offset_y <= csr_data[15:0];
            REG_ACCEL_NOISE_X:    cfg_ff.accel_noise_x <= csr_data[14:0];
            REG_ACCEL_NOISE_Y:    cfg_ff.accel_noise_y <= csr_data[14:0];
            REG_GYRO_WEIGHT:      cfg_ff.gyro_weight <= csr_data;
            REG_FUSED_WEIGHT:     cfg_ff.fused_weight <= csr_data;
            default: ;
         endcase
      end
   end

   ddof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddof_datapath #(
      .DIST_PER_COUNT (DIST_PER_COUNT),
      .INV_WHEEL_BASE (INV_WHEEL_BASE),
      .GYRO_SCALE     (GYRO_SCALE),
      .ACCEL_SCALE    (ACCEL_SCALE),
      .CORDIC_STEPS   (CORDIC_STEPS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg                 (cfg_ff),
      .req_left_counts     (req_left_counts),
      .req_right_counts    (req_right_counts),
      .req_gyro_z_raw      (req_gyro_z_raw),
      .req_accel_x_raw     (req_accel_x_raw),
      .req_accel_y_raw     (req_accel_y_raw),
      .req_elapsed_ms      (req_elapsed_ms),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_heading         (rsp_heading),
      .rsp_travel_distance (rsp_travel_distance)
   );
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import ddof_pkg::*;

   localparam longint TWO_PI   = 411775;
   localparam longint PI_Q16   = 205887;
   localparam longint HALF_PI  = 102944;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [15:0] left_counts;
      logic signed [15:0] right_counts;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic        [15:0] elapsed_ms;
   } tick_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [18:0] heading;
      logic [31:0] travel;
   } fix_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_left_counts = 0, req_right_counts = 0, req_gyro_z_raw = 0;
   logic signed [15:0] req_accel_x_raw = 0, req_accel_y_raw = 0;
   logic [15:0] req_elapsed_ms = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_travel_distance;
   logic [18:0] rsp_heading;
   logic csr_we = 0;
   logic [2:0] csr_index = REG_GYRO_OFFSET_Z;
   logic [16:0] csr_data = 0;

   diff_drive_odometry_fusion DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_counts(req_left_counts), .req_right_counts(req_right_counts),
      .req_gyro_z_raw(req_gyro_z_raw), .req_accel_x_raw(req_accel_x_raw),
      .req_accel_y_raw(req_accel_y_raw), .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_heading(rsp_heading),
      .rsp_travel_distance(rsp_travel_distance),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   tick_type tick_pending[$];
   fix_type  expected_fixes[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_go = 0;
   logic hold_done = 0;
   int hold_cnt = 0;
   longint cycles = 0;

   // predictor state and register copies
   longint gyro_off, gyro_noise, acc_off_x, acc_off_y, acc_noise_x, acc_noise_y;
   longint w_gyro, w_fused;
   longint head_q16, rate_cur, rate_prev;
   logic [31:0] gx, gy, travel_sum;
   longint arctan_q16[24];

   initial begin
      arctan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
   end

   function automatic longint atan2_q16(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += arctan_q16[i];
         end else begin
            x -= ys; y += xs; z -= arctan_q16[i];
         end
      end
      return z;
   endfunction

   task automatic rotate_heading(input longint a, output longint c, output longint s);
      longint x, y, z, xs, ys;
      bit neg;
      x = GAIN_Q30; y = 0; z = a; neg = 0;
      if (z > PI_Q16) z -= TWO_PI;
      if (z > HALF_PI) begin
         z -= PI_Q16; neg = 1;
      end else if (z < -HALF_PI) begin
         z += PI_Q16; neg = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_q16[i];
         end else begin
            x += ys; y -= xs; z += arctan_q16[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   function automatic longint gated_accel(longint a, longint off, longint noise);
      longint v;
      if (!(a >= 2 * noise || a <= -2 * noise)) return 0;
      v = ((a - off) * ACCEL_SCALE_DEF) >>> 8;
      if (v <= 1966 && v >= -1966) return 0;
      return v;
   endfunction

   task automatic predict_odometry(input tick_type t);
      longint lc, rc, g, dt, center, ax, ay, d_gyro, d_enc, d_acc, ang, th, c, s;
      fix_type f;
      lc = t.left_counts; rc = t.right_counts; g = t.gyro_z;
      dt = longint'(t.elapsed_ms);
      center = ((lc + rc) * DIST_PER_COUNT_DEF) >>> 17;
      travel_sum += center[31:0];
      if (g >= gyro_noise || g <= -gyro_noise) begin
         rate_prev = rate_cur;
         rate_cur = ((g - gyro_off) * GYRO_SCALE_DEF) >>> 8;
      end else begin
         rate_cur = 0;
      end
      ax = gated_accel(longint'(t.accel_x), acc_off_x, acc_noise_x);
      ay = gated_accel(longint'(t.accel_y), acc_off_y, acc_noise_y);
      d_gyro = ((rate_prev + rate_cur) * dt) / 2000;
      d_enc = ((rc - lc) * DIST_PER_COUNT_DEF * INV_WHEEL_BASE_DEF) >>> 32;
      d_acc = atan2_q16(ay, ax);
      ang = (w_gyro * d_gyro + (65536 - w_gyro) * d_acc) >>> 16;
      ang = (w_fused * ang + (65536 - w_fused) * d_enc) >>> 16;
      th = head_q16 + ang;
      if (th > TWO_PI) th -= TWO_PI;
      else if (th < 0) th += TWO_PI;
      if (th < 0) th = 0;
      if (th > TWO_PI) th = TWO_PI;
      head_q16 = th;
      rotate_heading(th, c, s);
      gx += 32'((center * c) >>> 30);
      gy += 32'((center * s) >>> 30);
      f.pos_x = gx; f.pos_y = gy; f.heading = th[18:0]; f.travel = travel_sum;
      expected_fixes.push_back(f);
   endtask

   // driver
   always @(posedge clock) begin
      tick_type t;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) predict_odometry({req_left_counts, req_right_counts,
            req_gyro_z_raw, req_accel_x_raw, req_accel_y_raw, req_elapsed_ms});
         if (!req_valid || req_ready) begin
            if (tick_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               t = tick_pending.pop_front();
               req_valid <= 1;
               req_left_counts <= t.left_counts;
               req_right_counts <= t.right_counts;
               req_gyro_z_raw <= t.gyro_z;
               req_accel_x_raw <= t.accel_x;
               req_accel_y_raw <= t.accel_y;
               req_elapsed_ms <= t.elapsed_ms;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_done <= 0;
      end else if (hold_go && !hold_done) begin
         hold_cnt <= 3000;
         hold_done <= 1;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= (hold_cnt == 0) && !(hold_go && !hold_done)
                        && ($urandom_range(99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      fix_type f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fixes.size() == 0) begin
            $display("%0t: unexpected beat x=%0d y=%0d hdg=%0d dist=%0d", $time,
                     rsp_pos_x, rsp_pos_y, rsp_heading, rsp_travel_distance);
            errors++;
         end else begin
            f = expected_fixes.pop_front();
            if (rsp_pos_x !== f.pos_x) begin
               $display("%0t: pos_x expected %0d got %0d", $time,
                        $signed(f.pos_x), rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== f.pos_y) begin
               $display("%0t: pos_y expected %0d got %0d", $time,
                        $signed(f.pos_y), rsp_pos_y);
               errors++;
            end
            if (rsp_heading !== f.heading) begin
               $display("%0t: heading expected %0d got %0d", $time, f.heading, rsp_heading);
               errors++;
            end
            if (rsp_travel_distance !== f.travel) begin
               $display("%0t: travel_distance expected %0d got %0d", $time,
                        $signed(f.travel), rsp_travel_distance);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** diff_drive_odometry_fusion: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input longint value);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= value[16:0];
      case (idx)
         REG_GYRO_OFFSET_Z:    gyro_off = longint'($signed(value[15:0]));
         REG_GYRO_NOISE_LEVEL: gyro_noise = value & 'h7FFF;
         REG_ACCEL_OFFSET_X:   acc_off_x = longint'($signed(value[15:0]));
         REG_ACCEL_OFFSET_Y:   acc_off_y = longint'($signed(value[15:0]));
         REG_ACCEL_NOISE_X:    acc_noise_x = value & 'h7FFF;
         REG_ACCEL_NOISE_Y:    acc_noise_y = value & 'h7FFF;
         REG_GYRO_WEIGHT:      w_gyro = value & 'h1FFFF;
         default:              w_fused = value & 'h1FFFF;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_filter(input longint goff, input longint gn, input longint axo,
                             input longint ayo, input longint nx, input longint ny,
                             input longint wg, input longint wf);
      write_reg(REG_GYRO_OFFSET_Z, goff);
      write_reg(REG_GYRO_NOISE_LEVEL, gn);
      write_reg(REG_ACCEL_OFFSET_X, axo);
      write_reg(REG_ACCEL_OFFSET_Y, ayo);
      write_reg(REG_ACCEL_NOISE_X, nx);
      write_reg(REG_ACCEL_NOISE_Y, ny);
      write_reg(REG_GYRO_WEIGHT, wg);
      write_reg(REG_FUSED_WEIGHT, wf);
   endtask

   function automatic logic signed [15:0] near(int span);
      return 16'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      int kind;
      kind = $urandom_range(9);
      t = tick_type'({$urandom, $urandom, $urandom});
      if (kind < 6) begin
         // typical driving tick
         t.left_counts = near(400);
         t.right_counts = t.left_counts + near(60);
         t.gyro_z = near(3000);
         t.accel_x = near(20000);
         t.accel_y = near(20000);
         t.elapsed_ms = 16'($urandom_range(1, 40));
      end else if (kind == 9) begin
         t.left_counts = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
         t.right_counts = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
         t.elapsed_ms = $urandom_range(1) ? 16'hffff : 16'h0000;
      end
      return t;
   endfunction

   task automatic add_tick(input int l, input int r, input int g, input int ax,
                           input int ay, input int dt);
      tick_type t;
      t.left_counts = 16'(l); t.right_counts = 16'(r); t.gyro_z = 16'(g);
      t.accel_x = 16'(ax); t.accel_y = 16'(ay); t.elapsed_ms = 16'(dt);
      tick_pending.push_back(t);
   endtask

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) tick_pending.push_back(random_tick());
   endtask

   task automatic drain();
      while (tick_pending.size() != 0 || req_valid || expected_fixes.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      gyro_off = 0; gyro_noise = 0; acc_off_x = 0; acc_off_y = 0;
      acc_noise_x = 0; acc_noise_y = 0; w_gyro = 62259; w_fused = 32768;
      head_q16 = 0; rate_cur = 0; rate_prev = 0;
      gx = 0; gy = 0; travel_sum = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed ticks under reset settings, no idling
      add_tick(0, 0, 0, 0, 0, 0);
      add_tick(32767, 32767, 32767, 32767, 32767, 65535);
      add_tick(-32768, -32768, -32768, -32768, -32768, 65535);
      add_tick(-32768, 32767, 0, 0, 0, 10);
      add_tick(32767, -32768, 0, 0, 0, 10);
      add_tick(100, 100, 0, 400, -400, 5);     // accel below the small limit
      add_tick(100, 120, 0, -20000, 0, 5);     // atan2 on negative x axis
      add_tick(100, 120, 0, -20000, -9000, 5);
      add_tick(50, 50, 0, 0, 20000, 5);
      add_tick(50, 50, 0, 0, -20000, 5);
      add_tick(10, 10, 32767, 0, 0, 65535);    // big turn forward
      add_tick(10, 10, -32768, 0, 0, 65535);   // big turn back
      add_tick(10, 10, -32768, 0, 0, 65535);
      run_random(8);
      drain();

      // gate levels right at the sample, then saturation-size turns
      set_filter(100, 500, -200, 300, 1000, 1000, 65536, 65536);
      add_tick(20, 30, 500, 2000, -2000, 20);
      add_tick(20, 30, -500, 1999, -1999, 20);
      add_tick(20, 30, 499, 2001, 1998, 20);
      add_tick(20, 30, -499, 0, 0, 20);
      add_tick(0, 0, 32767, 0, 0, 65535);
      add_tick(0, 0, 32767, 0, 0, 65535);
      send_idle_pct = 81;
      run_random(370);
      drain();

      // register extremes, receiver stalls
      set_filter(-32768, 32767, 32767, -32768, 32767, 0, 0, 0);
      send_idle_pct = 0; stall_pct = 81;
      run_random(380);
      drain();

      // weights above one, both sides idle a little, with a long hold-off
      set_filter(32767, 0, -32768, 32767, 0, 32767, 131071, 131071);
      send_idle_pct = 10; stall_pct = 10;
      hold_go <= 1;
      run_random(380);
      drain();

      set_filter(longint'(near(2000)), $urandom_range(200), longint'(near(2000)),
                 longint'(near(2000)), $urandom_range(300), $urandom_range(300),
                 $urandom_range(65536), $urandom_range(65536));
      send_idle_pct = 0; stall_pct = 0;
      run_random(380);
      drain();

      set_filter(0, 0, 0, 0, 0, 0, 62259, 32768);
      send_idle_pct = 40; stall_pct = 40;
      run_random(380);
      drain();

      if (errors == 0) $display("** diff_drive_odometry_fusion: PASSED **");
      else $display("** diff_drive_odometry_fusion: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/ddof_pkg.sv
src/ddof_ctrl.sv
src/ddof_datapath.sv
src/diff_drive_odometry_fusion.sv
tb/sv/tb.sv
